FILE: src/cbsd_pkg.sv
// ----------------------------------------------------------------------------
// cbsd_pkg
// shared constants, types and the reciprocal table for the cursor shape
// decoder
// ----------------------------------------------------------------------------
package cbsd_pkg;

    localparam int MAX_WIDTH     = 64;
    localparam int MAX_HEIGHT    = 64;
    localparam int ROW_BYTES_MAX = (MAX_WIDTH + 7) / 8;
    localparam int PLANE_DEPTH   = ROW_BYTES_MAX * MAX_HEIGHT;
    localparam int PLANE_AW      = $clog2(PLANE_DEPTH);
    localparam int PLANE_W       = $clog2(PLANE_DEPTH + 1);
    localparam int BPR_W         = $clog2(ROW_BYTES_MAX + 1);
    localparam int COLB_W        = $clog2(ROW_BYTES_MAX);
    localparam int DIM_W         = 7;
    localparam int POS_W         = 11;
    localparam int COL_W         = 6;
    localparam int ROW_W         = 6;
    localparam int RGB_W         = 24;
    localparam int COLOUR_BYTES  = 6;
    localparam logic [7:0] OPAQUE_ALPHA = 8'hFF;

    localparam int RECIP_SHIFT   = 12;
    localparam int RECIP_ONE     = 1 << RECIP_SHIFT;
    localparam int RECIP_W       = RECIP_SHIFT + 1;
    localparam int QE_W          = PLANE_AW + 1;
    localparam int QPROD_W       = PLANE_AW + RECIP_W;
    localparam int LPROD_W       = QE_W + BPR_W;

    localparam int CFG_IDX_W     = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_HEIGHT = 2'd1;

    typedef struct packed {
        logic [7:0]        mask;
        logic [7:0]        pix;
        logic [ROW_W-1:0]  row;
        logic [COLB_W-1:0] colbyte;
        logic [RGB_W-1:0]  fore;
        logic [RGB_W-1:0]  back;
    } t_emit_load;

    // ceil(2^RECIP_SHIFT / d) for the row byte counts
    function automatic logic [RECIP_W-1:0] recip(input logic [BPR_W-1:0] d);
        logic [RECIP_W-1:0] r;
        case (d)
            BPR_W'(1): r = RECIP_W'(RECIP_ONE);
            BPR_W'(2): r = RECIP_W'((RECIP_ONE + 1) / 2);
            BPR_W'(3): r = RECIP_W'((RECIP_ONE + 2) / 3);
            BPR_W'(4): r = RECIP_W'((RECIP_ONE + 3) / 4);
            BPR_W'(5): r = RECIP_W'((RECIP_ONE + 4) / 5);
            BPR_W'(6): r = RECIP_W'((RECIP_ONE + 5) / 6);
            BPR_W'(7): r = RECIP_W'((RECIP_ONE + 6) / 7);
            BPR_W'(8): r = RECIP_W'((RECIP_ONE + 7) / 8);
            default:   r = RECIP_W'(RECIP_ONE);
        endcase
        return r;
    endfunction

endpackage

FILE: src/cursor_bitmap_shape_decoder_top.sv
// ----------------------------------------------------------------------------
// cursor_bitmap_shape_decoder_top
// two-colour cursor shape decoder: colours, stored pixel plane, mask plane
// decoded into opaque argb pixels with coordinates
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-----------------------------
//   input    | in        | i_valid / o_stall      | i_stream_byte, i_shape_start
//   output   | out       | o_valid / i_stall      | o_pixel_col, o_pixel_row,
//            |           |                        | o_pixel_argb, o_run_end
//   config   | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// colour and pixel plane bytes are taken without stalling the input
// a mask byte passes the states accept and plane read, reciprocal divide,
// correction and load, and the emitter then gives one word per cycle while
// the output is not stalled; a mask byte is loaded only once the emitter is empty
// the plane memory needs no clearing pass
// an output stall holds the word; o_stall is high while a mask byte is decoded
// or waits for the emitter
// ----------------------------------------------------------------------------
module cursor_bitmap_shape_decoder_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_stream_byte,
    input  logic                              i_shape_start,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [cbsd_pkg::COL_W-1:0]        o_pixel_col,
    output logic [cbsd_pkg::ROW_W-1:0]        o_pixel_row,
    output logic [31:0]                       o_pixel_argb,
    output logic                              o_run_end,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cbsd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cbsd_pkg::DIM_W-1:0]        i_cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_LOAD} t_state;

    t_state                              r_state;
    logic [cbsd_pkg::POS_W-1:0]          r_pos;
    logic [cbsd_pkg::RGB_W-1:0]          r_fore;
    logic [cbsd_pkg::RGB_W-1:0]          r_back;
    logic [cbsd_pkg::DIM_W-1:0]          r_width;
    logic [cbsd_pkg::DIM_W-1:0]          r_height;
    logic [cbsd_pkg::DIM_W-1:0]          r_eff_w;
    logic [cbsd_pkg::BPR_W-1:0]          r_bpr;
    logic [cbsd_pkg::PLANE_W-1:0]        r_plane;
    logic [cbsd_pkg::POS_W-1:0]          r_total;
    logic [cbsd_pkg::PLANE_AW-1:0]       r_m;
    logic [7:0]                          r_mask;
    logic [cbsd_pkg::QE_W-1:0]           r_qe;

    logic                                cfg_acc;
    logic [cbsd_pkg::DIM_W-1:0]          n_width;
    logic [cbsd_pkg::DIM_W-1:0]          n_height;
    logic [cbsd_pkg::DIM_W-1:0]          w_eff;
    logic [cbsd_pkg::DIM_W-1:0]          h_eff;
    logic [cbsd_pkg::DIM_W:0]            w_round;
    logic [cbsd_pkg::BPR_W-1:0]          n_bpr;
    logic [cbsd_pkg::BPR_W+cbsd_pkg::DIM_W-1:0] plane_prod;
    logic [cbsd_pkg::PLANE_W-1:0]        n_plane;
    logic [cbsd_pkg::POS_W-1:0]          n_total;

    logic                                in_acc;
    logic [cbsd_pkg::POS_W-1:0]          p;
    logic [cbsd_pkg::POS_W-1:0]          idx;
    logic [cbsd_pkg::POS_W-1:0]          m_full;
    logic                                live;
    logic                                is_colour;
    logic                                is_plane;
    logic                                ram_we;
    logic                                ram_re;
    logic [7:0]                          ram_rdata;

    logic [cbsd_pkg::QPROD_W-1:0]        qprod;
    logic [cbsd_pkg::LPROD_W-1:0]        lprod;
    logic [cbsd_pkg::LPROD_W-1:0]        m_ext;
    logic [cbsd_pkg::LPROD_W-1:0]        bpr_ext;
    logic [cbsd_pkg::LPROD_W-1:0]        rem;
    logic                                over;
    logic [cbsd_pkg::QE_W-1:0]           quot;
    logic [cbsd_pkg::COLB_W-1:0]         colbyte;
    logic [cbsd_pkg::DIM_W:0]            span;
    logic [3:0]                          vcnt;
    logic [7:0]                          keep;
    cbsd_pkg::t_emit_load                load;
    logic                                load_en;
    logic                                emit_ready;

    // register file and derived shape geometry
    always_comb begin
        cfg_acc  = i_cfg_valid && o_cfg_ready;
        n_width  = r_width;
        n_height = r_height;
        if (cfg_acc) begin
            case (i_cfg_index)
                cbsd_pkg::CFG_SHAPE_WIDTH:  n_width  = i_cfg_data;
                cbsd_pkg::CFG_SHAPE_HEIGHT: n_height = i_cfg_data;
                default: ;
            endcase
        end
        w_eff   = (n_width > cbsd_pkg::MAX_WIDTH) ?
                  cbsd_pkg::DIM_W'(cbsd_pkg::MAX_WIDTH) : n_width;
        h_eff   = (n_height > cbsd_pkg::MAX_HEIGHT) ?
                  cbsd_pkg::DIM_W'(cbsd_pkg::MAX_HEIGHT) : n_height;
        w_round = (cbsd_pkg::DIM_W+1)'(w_eff) + (cbsd_pkg::DIM_W+1)'(7);
        n_bpr   = (w_eff == '0 || h_eff == '0) ? '0 : cbsd_pkg::BPR_W'(w_round >> 3);
        plane_prod = (cbsd_pkg::BPR_W+cbsd_pkg::DIM_W)'(n_bpr)
                   * (cbsd_pkg::BPR_W+cbsd_pkg::DIM_W)'(h_eff);
        n_plane = cbsd_pkg::PLANE_W'(plane_prod);
        n_total = cbsd_pkg::POS_W'(cbsd_pkg::COLOUR_BYTES)
                + cbsd_pkg::POS_W'({n_plane, 1'b0});
    end

    // input byte classification
    always_comb begin
        in_acc    = i_valid && !o_stall;
        p         = i_shape_start ? '0 : r_pos;
        live      = (p < r_total);
        idx       = p - cbsd_pkg::POS_W'(cbsd_pkg::COLOUR_BYTES);
        m_full    = idx - cbsd_pkg::POS_W'(r_plane);
        is_colour = (p < cbsd_pkg::POS_W'(cbsd_pkg::COLOUR_BYTES));
        is_plane  = (idx < cbsd_pkg::POS_W'(r_plane));
        ram_we    = in_acc && live && !is_colour && is_plane;
        ram_re    = in_acc && live && !is_colour && !is_plane;
    end

    // row and column byte of the mask byte: reciprocal estimate then correction
    always_comb begin
        qprod   = cbsd_pkg::QPROD_W'(r_m) * cbsd_pkg::QPROD_W'(cbsd_pkg::recip(r_bpr));
        lprod   = cbsd_pkg::LPROD_W'(r_qe) * cbsd_pkg::LPROD_W'(r_bpr);
        m_ext   = cbsd_pkg::LPROD_W'(r_m);
        bpr_ext = cbsd_pkg::LPROD_W'(r_bpr);
        over    = (lprod > m_ext);
        quot    = over ? (r_qe - cbsd_pkg::QE_W'(1)) : r_qe;
        rem     = over ? (m_ext + bpr_ext - lprod) : (m_ext - lprod);
        colbyte = rem[cbsd_pkg::COLB_W-1:0];
        span    = (cbsd_pkg::DIM_W+1)'(r_eff_w)
                - (cbsd_pkg::DIM_W+1)'({colbyte, 3'b000});
        vcnt    = (span > (cbsd_pkg::DIM_W+1)'(8)) ? 4'd8 : span[3:0];
        keep    = ~(8'hFF >> vcnt);

        load.mask    = r_mask & keep;
        load.pix     = ram_rdata;
        load.row     = cbsd_pkg::ROW_W'(quot);
        load.colbyte = colbyte;
        load.fore    = r_fore;
        load.back    = r_back;
        load_en      = (r_state == S_LOAD) && emit_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= '0;
            r_fore   <= '0;
            r_back   <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_eff_w  <= '0;
            r_bpr    <= '0;
            r_plane  <= '0;
            r_total  <= cbsd_pkg::POS_W'(cbsd_pkg::COLOUR_BYTES);
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_eff_w  <= w_eff;
            r_bpr    <= n_bpr;
            r_plane  <= n_plane;
            r_total  <= n_total;
            case (r_state)
                S_IDLE: begin
                    if (in_acc && live) begin
                        r_pos <= p + cbsd_pkg::POS_W'(1);
                        if (is_colour) begin
                            case (p[2:0])
                                3'd0:    r_fore[23:16] <= i_stream_byte;
                                3'd1:    r_fore[15:8]  <= i_stream_byte;
                                3'd2:    r_fore[7:0]   <= i_stream_byte;
                                3'd3:    r_back[23:16] <= i_stream_byte;
                                3'd4:    r_back[15:8]  <= i_stream_byte;
                                3'd5:    r_back[7:0]   <= i_stream_byte;
                                default: ;
                            endcase
                        end else if (!is_plane) begin
                            r_m     <= m_full[cbsd_pkg::PLANE_AW-1:0];
                            r_mask  <= i_stream_byte;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_qe    <= qprod[cbsd_pkg::RECIP_SHIFT +: cbsd_pkg::QE_W];
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (emit_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    cbsd_plane_ram #(
        .DEPTH (cbsd_pkg::PLANE_DEPTH),
        .WIDTH (8),
        .AW    (cbsd_pkg::PLANE_AW)
    ) u_plane_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (idx[cbsd_pkg::PLANE_AW-1:0]),
        .i_wdata (i_stream_byte),
        .i_re    (ram_re),
        .i_raddr (m_full[cbsd_pkg::PLANE_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    cbsd_pixel_emit u_pixel_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_en    (load_en),
        .i_load       (load),
        .o_ready      (emit_ready),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pixel_col  (o_pixel_col),
        .o_pixel_row  (o_pixel_row),
        .o_pixel_argb (o_pixel_argb),
        .o_run_end    (o_run_end)
    );

endmodule

FILE: src/cbsd_plane_ram.sv
// ----------------------------------------------------------------------------
// cbsd_plane_ram
// simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module cbsd_plane_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/cbsd_pixel_emit.sv
// ----------------------------------------------------------------------------
// cbsd_pixel_emit
// serializes the opaque pixels of one mask byte, msb first, into an output
// register
// ----------------------------------------------------------------------------
module cbsd_pixel_emit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load_en,
    input  cbsd_pkg::t_emit_load          i_load,
    output logic                          o_ready,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [cbsd_pkg::COL_W-1:0]    o_pixel_col,
    output logic [cbsd_pkg::ROW_W-1:0]    o_pixel_row,
    output logic [31:0]                   o_pixel_argb,
    output logic                          o_run_end
);

    logic [7:0]                        r_mask;
    logic [7:0]                        r_pix;
    logic [cbsd_pkg::ROW_W-1:0]        r_row;
    logic [cbsd_pkg::COLB_W-1:0]       r_colbyte;
    logic [cbsd_pkg::RGB_W-1:0]        r_fore;
    logic [cbsd_pkg::RGB_W-1:0]        r_back;
    logic                              r_o_valid;
    logic [cbsd_pkg::COL_W-1:0]        r_o_col;
    logic [cbsd_pkg::ROW_W-1:0]        r_o_row;
    logic [31:0]                       r_o_argb;
    logic                              r_o_run_end;

    logic [2:0]                        sel;
    logic [7:0]                        onehot;
    logic [7:0]                        n_mask;
    logic                              advance;
    logic [cbsd_pkg::COLB_W+2:0]       col_full;

    // highest set bit of the remaining mask
    always_comb begin
        sel = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (r_mask[i]) begin
                sel = 3'(i);
            end
        end
        onehot   = 8'b1 << sel;
        n_mask   = r_mask & ~onehot;
        advance  = (r_mask != 8'd0) && (!r_o_valid || !i_stall);
        col_full = {r_colbyte, 3'(3'd7 - sel)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= 8'd0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_load_en) begin
                r_mask    <= i_load.mask;
                r_pix     <= i_load.pix;
                r_row     <= i_load.row;
                r_colbyte <= i_load.colbyte;
                r_fore    <= i_load.fore;
                r_back    <= i_load.back;
            end else if (advance) begin
                r_mask <= n_mask;
            end
            if (advance) begin
                r_o_valid   <= 1'b1;
                r_o_col     <= cbsd_pkg::COL_W'(col_full);
                r_o_row     <= r_row;
                r_o_argb    <= {cbsd_pkg::OPAQUE_ALPHA, r_pix[sel] ? r_fore : r_back};
                r_o_run_end <= (n_mask == 8'd0);
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_ready      = (r_mask == 8'd0);
    assign o_valid      = r_o_valid;
    assign o_pixel_col  = r_o_col;
    assign o_pixel_row  = r_o_row;
    assign o_pixel_argb = r_o_argb;
    assign o_run_end    = r_o_run_end;

endmodule

FILE: src/cbsd_checker.sv
// ----------------------------------------------------------------------------
// cbsd_checker
// port level checks for the cursor shape decoder, bound to the top level
// ----------------------------------------------------------------------------
module cbsd_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_valid,
    input  logic                              i_stall,
    input  logic [cbsd_pkg::COL_W-1:0]        o_pixel_col,
    input  logic [cbsd_pkg::ROW_W-1:0]        o_pixel_row,
    input  logic [31:0]                       o_pixel_argb,
    input  logic                              o_run_end
);

    // every pixel is opaque
    a_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel_argb[31:24] == cbsd_pkg::OPAQUE_ALPHA))
        else $error("pixel word without full alpha");

    // within one run the next word follows at once, same row, further right
    a_run_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(o_valid && !i_stall && !o_run_end)) |->
        (o_valid && o_pixel_row == $past(o_pixel_row)
                 && o_pixel_col > $past(o_pixel_col)))
        else $error("run broken or out of column order");

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(o_valid && i_stall)) |->
        (o_valid && $stable(o_pixel_col) && $stable(o_pixel_row)
                 && $stable(o_pixel_argb) && $stable(o_run_end)))
        else $error("stalled word changed");

    // no word right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> !o_valid)
        else $error("output valid right after reset");

endmodule

bind cursor_bitmap_shape_decoder_top cbsd_checker u_cbsd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_pixel_col  (o_pixel_col),
    .o_pixel_row  (o_pixel_row),
    .o_pixel_argb (o_pixel_argb),
    .o_run_end    (o_run_end)
);
